// ----- sv/fbaa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbaa_pkg
// Shared types and constants of the file block append allocator.
// ----------------------------------------------------------------------------
package fbaa_pkg;

    localparam int INODES         = 64;
    localparam int DISK_BLOCKS    = 2048;
    localparam int BLOCK_BYTES    = 1024;
    localparam int DIRECT_SLOTS   = 12;
    localparam int INDIRECT_SLOTS = 256;
    localparam int MAX_APPEND     = 8192;
    localparam int MAP_BLOCKS     = DIRECT_SLOTS + INDIRECT_SLOTS;
    localparam int WORD_BITS      = 32;
    localparam int BM_WORDS       = DISK_BLOCKS / WORD_BITS;

    // result error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_SPACE = 2'd1;
    localparam logic [1:0] ERR_TOO_BIG  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_DATA_BASE  = 2'd0;
    localparam logic [1:0] CFG_DATA_COUNT = 2'd1;
    localparam logic [1:0] CFG_RESERVED   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_CHUNK,
        ST_SLOT,
        ST_ALLOC,
        ST_EMIT
    } fbaa_state_t;

    typedef enum logic [1:0] {
        BM_IDLE,
        BM_READ,
        BM_EVAL
    } bm_state_t;

    // free block search request and response
    typedef struct packed {
        logic        start;
        logic [11:0] lo;
        logic [11:0] hi;
    } srch_req_t;

    typedef struct packed {
        logic        done;
        logic        found;
        logic [10:0] bit_index;
    } srch_resp_t;

endpackage

// ----- sv/file_block_append_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_block_append_allocator
// Appends bytes to files through a direct plus single-indirect block map.
// ----------------------------------------------------------------------------
// One append is taken at a time and yields one result per block chunk, and a
// failing chunk yields one error result that ends the append. A chunk inside an
// already mapped block reads its slot entry; a chunk that needs a new block walks
// the 32-bit bitmap words from the reserved boundary to the first free bit, and
// walks them once more when the indirect block has to be taken first. The
// bitmap search over the word memory sets the rate. Slot entries are read
// only below the file size, so no clearing pass is needed.
module file_block_append_allocator
    import fbaa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [5:0]  s_inode_number,
    input  logic [13:0] s_byte_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [10:0] m_block_address,
    output logic [9:0]  m_block_offset,
    output logic [10:0] m_chunk_length,
    output logic [18:0] m_final_size,
    output logic [1:0]  m_error_code,
    output logic        m_last
);

    fbaa_state_t  state_reg, state_next;
    logic [10:0]  data_base_reg;
    logic [11:0]  data_count_reg, reserved_reg;
    logic [5:0]   ino_reg, ino_next;
    logic [13:0]  remain_reg, remain_next;
    logic [18:0]  size_reg, size_next;
    logic [10:0]  addr_reg, addr_next;
    logic [1:0]   err_reg, err_next;
    logic         ind_reg, ind_next;
    logic [INODES-1:0] has_ind_reg, has_ind_next;
    logic [INODES-1:0] len_vld_reg, len_vld_next;
    logic         len_hit_reg;

    logic [18:0]  len_mem [INODES];
    logic [18:0]  len_rdata_reg;
    logic         len_we;
    logic [10:0]  slot_mem [INODES * 512];
    logic [10:0]  slot_rdata_reg;
    logic         slot_we;

    logic         m_valid_reg, out_load, out_free;
    logic [10:0]  m_addr_reg;
    logic [9:0]   m_off_reg;
    logic [10:0]  m_len_reg;
    logic [18:0]  m_size_reg;
    logic [1:0]   m_err_reg;
    logic         m_last_reg;

    logic [9:0]   off;
    logic [8:0]   bidx;
    logic [10:0]  room, chunk;
    logic [14:0]  slot_addr;
    logic [10:0]  new_addr;
    logic         srch_start;
    srch_req_t    srch_req;
    srch_resp_t   srch_resp;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_base_reg  <= 11'd46;
            data_count_reg <= 12'd1954;
            reserved_reg   <= 12'd46;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DATA_BASE:  data_base_reg  <= cfg_data[10:0];
                CFG_DATA_COUNT: data_count_reg <= cfg_data;
                CFG_RESERVED:   reserved_reg   <= cfg_data;
                default: ;
            endcase
        end
    end
    assign cfg_ready = 1'b1;

    // search window of the bitmap
    always_comb begin
        srch_req.start = srch_start;
        srch_req.lo    = reserved_reg;
        if (data_base_reg == 11'd0 && reserved_reg == 12'd0) begin
            srch_req.lo = 12'd1;
        end
        srch_req.hi = 12'(DISK_BLOCKS) - {1'b0, data_base_reg};
        if (data_count_reg < srch_req.hi) begin
            srch_req.hi = data_count_reg;
        end
    end

    fbaa_bitmap u_bitmap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (srch_req),
        .resp    (srch_resp)
    );

    // chunk geometry from the current size
    always_comb begin
        off       = size_reg[9:0];
        bidx      = size_reg[18:10];
        room      = 11'(BLOCK_BYTES) - {1'b0, off};
        chunk     = ({3'd0, room} > remain_reg) ? remain_reg[10:0] : room;
        slot_addr = {ino_reg, bidx};
        new_addr  = data_base_reg + srch_resp.bit_index;
    end

    // file length and slot memories
    always_ff @(posedge aclk) begin
        len_rdata_reg  <= len_mem[s_inode_number];
        slot_rdata_reg <= slot_mem[slot_addr];
        if (len_we) begin
            len_mem[ino_reg] <= size_next;
        end
        if (slot_we) begin
            slot_mem[slot_addr] <= new_addr;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // append sequencer
    always_comb begin
        state_next   = state_reg;
        ino_next     = ino_reg;
        remain_next  = remain_reg;
        size_next    = size_reg;
        addr_next    = addr_reg;
        err_next     = err_reg;
        ind_next     = ind_reg;
        has_ind_next = has_ind_reg;
        len_vld_next = len_vld_reg;
        len_we       = 1'b0;
        slot_we      = 1'b0;
        out_load     = 1'b0;
        srch_start   = 1'b0;
        s_ready      = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    ino_next    = s_inode_number;
                    remain_next = (s_byte_count > 14'(MAX_APPEND))
                                  ? 14'(MAX_APPEND) : s_byte_count;
                    state_next  = ST_LEN;
                end
            end
            ST_LEN: begin
                size_next  = len_hit_reg ? len_rdata_reg : '0;
                state_next = (remain_reg == '0) ? ST_IDLE : ST_CHUNK;
            end
            ST_CHUNK: begin
                err_next = ERR_NONE;
                if (bidx >= 9'(MAP_BLOCKS)) begin
                    err_next   = ERR_TOO_BIG;
                    state_next = ST_EMIT;
                end else if (off != '0) begin
                    state_next = ST_SLOT;
                end else begin
                    srch_start = 1'b1;
                    ind_next   = (bidx >= 9'(DIRECT_SLOTS)) && !has_ind_reg[ino_reg];
                    state_next = ST_ALLOC;
                end
            end
            ST_SLOT: begin
                addr_next  = slot_rdata_reg;
                state_next = ST_EMIT;
            end
            ST_ALLOC: begin
                if (srch_resp.done) begin
                    if (!srch_resp.found) begin
                        err_next   = ERR_NO_SPACE;
                        state_next = ST_EMIT;
                    end else if (ind_reg) begin
                        has_ind_next[ino_reg] = 1'b1;
                        state_next = ST_CHUNK;
                    end else begin
                        slot_we    = 1'b1;
                        addr_next  = new_addr;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (err_reg != ERR_NONE) begin
                        state_next = ST_IDLE;
                    end else begin
                        size_next    = size_reg + 19'(chunk);
                        remain_next  = remain_reg - 14'(chunk);
                        len_we       = 1'b1;
                        len_vld_next[ino_reg] = 1'b1;
                        state_next   = (remain_next == '0) ? ST_IDLE : ST_CHUNK;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            has_ind_reg <= '0;
            len_vld_reg <= '0;
        end else begin
            state_reg   <= state_next;
            has_ind_reg <= has_ind_next;
            len_vld_reg <= len_vld_next;
        end
        ino_reg     <= ino_next;
        remain_reg  <= remain_next;
        size_reg    <= size_next;
        addr_reg    <= addr_next;
        err_reg     <= err_next;
        ind_reg     <= ind_next;
        len_hit_reg <= len_vld_reg[s_inode_number];
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            if (err_reg != ERR_NONE) begin
                m_addr_reg <= '0;
                m_off_reg  <= '0;
                m_len_reg  <= '0;
                m_size_reg <= size_reg;
                m_last_reg <= 1'b1;
            end else begin
                m_addr_reg <= addr_reg;
                m_off_reg  <= off;
                m_len_reg  <= chunk;
                m_size_reg <= size_next;
                m_last_reg <= (remain_next == '0);
            end
            m_err_reg <= err_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_block_address = m_addr_reg;
    assign m_block_offset  = m_off_reg;
    assign m_chunk_length  = m_len_reg;
    assign m_final_size    = m_size_reg;
    assign m_error_code    = m_err_reg;
    assign m_last          = m_last_reg;

    // an error result closes the append and carries no bytes
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_error_code != ERR_NONE |-> m_last && m_chunk_length == '0)
        else $error("error result not final or not empty");

    // a found bit lies inside the search window
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_ALLOC && srch_resp.done && srch_resp.found
        |-> {1'b0, srch_resp.bit_index} < srch_req.hi)
        else $error("allocated bit outside the window");

    // existing slots are read only mid-block
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SLOT |-> size_reg[9:0] != '0)
        else $error("slot read on block boundary");

    // one append at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer accepted during append");

endmodule

// ----- sv/fbaa_bitmap.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbaa_bitmap
// Allocation bitmap in a word memory with a word-at-a-time free bit search.
// ----------------------------------------------------------------------------
module fbaa_bitmap
    import fbaa_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  srch_req_t  req,
    output srch_resp_t resp
);

    logic [WORD_BITS-1:0] mem [BM_WORDS];
    logic [WORD_BITS-1:0] rdata_reg;
    logic [BM_WORDS-1:0]  wvalid_reg, wvalid_next;
    bm_state_t            state_reg, state_next;
    logic [5:0]           word_reg, word_next;
    logic                 done_reg, done_next;
    logic                 found_reg, found_next;
    logic [10:0]          bit_reg, bit_next;
    logic                 wr_en;
    logic [WORD_BITS-1:0] cur_word, free_bits, wdata;
    logic [4:0]           first_free;
    logic [11:0]          word_end;

    // memory: registered read, one write port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[word_reg];
        if (wr_en) begin
            mem[word_reg] <= wdata;
        end
    end

    // word contents with never-written words read as clear
    always_comb begin
        cur_word = wvalid_reg[word_reg] ? rdata_reg : '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            free_bits[i] = !cur_word[i]
                && ({1'b0, word_reg, 5'(i)} >= req.lo)
                && ({1'b0, word_reg, 5'(i)} < req.hi);
        end
        first_free = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                first_free = 5'(i);
            end
        end
        word_end = {1'b0, word_reg, 5'd0} + 12'(WORD_BITS);
        wdata    = cur_word | (32'd1 << first_free);
    end

    // search sequencer
    always_comb begin
        state_next  = state_reg;
        word_next   = word_reg;
        wvalid_next = wvalid_reg;
        done_next   = 1'b0;
        found_next  = found_reg;
        bit_next    = bit_reg;
        wr_en       = 1'b0;
        case (state_reg)
            BM_IDLE: begin
                if (req.start) begin
                    if (req.lo >= req.hi) begin
                        done_next  = 1'b1;
                        found_next = 1'b0;
                    end else begin
                        word_next  = req.lo[10:5];
                        state_next = BM_READ;
                    end
                end
            end
            BM_READ: begin
                state_next = BM_EVAL;
            end
            BM_EVAL: begin
                if (|free_bits) begin
                    wr_en                 = 1'b1;
                    wvalid_next[word_reg] = 1'b1;
                    done_next             = 1'b1;
                    found_next            = 1'b1;
                    bit_next              = {word_reg, first_free};
                    state_next            = BM_IDLE;
                end else if (word_end >= req.hi) begin
                    done_next  = 1'b1;
                    found_next = 1'b0;
                    state_next = BM_IDLE;
                end else begin
                    word_next  = word_reg + 6'd1;
                    state_next = BM_READ;
                end
            end
            default: state_next = BM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= BM_IDLE;
            wvalid_reg <= '0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            wvalid_reg <= wvalid_next;
            done_reg   <= done_next;
            found_reg  <= found_next;
        end
        word_reg <= word_next;
        bit_reg  <= bit_next;
    end

    assign resp.done      = done_reg;
    assign resp.found     = found_reg;
    assign resp.bit_index = bit_reg;

endmodule
